// ===== design/ols_pkg.sv =====
`default_nettype none
package ols_pkg;

	localparam int FEAT_W     = 24;
	localparam int NF_MAX     = 16;
	localparam int NORM_FEATS = 9;
	localparam int W_W        = 32;
	localparam int PROD_W     = W_W + FEAT_W + 1;
	localparam int RATE_W     = 32;
	localparam int MAG_W      = 16;
	localparam int RE_W       = 31;
	localparam int PROB_W     = 16;
	localparam int ERR_W      = 17;
	localparam int LR_W       = 16;
	localparam int DECAY_W    = 17;
	localparam int CFG_W      = 17;

	localparam logic [FEAT_W-1:0] FEAT_SAT    = '1;
	localparam logic [RATE_W-1:0] RATE_RESET  = 32'd655 << 16;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd65536;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef logic [FEAT_W-1:0] feat_t;

	typedef enum logic [0:0] {
		REG_LEARNING_RATE    = 1'b0,
		REG_DECAY_PER_UPDATE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic mul_en;
		logic delta_en;
		logic upd_en;
		logic neg;
	} lane_ctrl_t;

	// Restoring division, used only while the sigmoid table is elaborated.
	function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-t in Q.30 for 0 <= t <= 8.0 in Q.30.
	function automatic logic [63:0] neg_exp_q30(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] mag;
		logic [63:0] e;
		logic signed [63:0] sum;
		u = t >> 4;
		mag = Q30_ONE;
		sum = $signed(Q30_ONE);
		for (int n = 1; n <= 12; n++) begin
			mag = div_u64((mag * u) >> 30, 64'(n));
			if ((n & 1) != 0) begin
				sum = sum - $signed(mag);
			end else begin
				sum = sum + $signed(mag);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		e = $unsigned(sum);
		if (e > Q30_ONE) begin
			e = Q30_ONE;
		end
		for (int s = 0; s < 4; s++) begin
			e = (e * e) >> 30;
		end
		return e;
	endfunction

	function automatic logic [PROB_W-1:0] sig_entry(input logic [63:0] k,
			input logic [63:0] depth);
		logic [63:0] num;
		logic signed [63:0] c;
		logic neg;
		logic [63:0] t;
		logic [63:0] e;
		logic [63:0] s30;
		logic [63:0] r;
		num = ((k << 1) + 64'd1) << 34;
		c = $signed(div_u64(num, depth << 1)) - $signed(64'd8 << 30);
		neg = c < 0;
		t = neg ? $unsigned(-c) : $unsigned(c);
		e = neg_exp_q30(t);
		s30 = neg ? div_u64(e << 30, Q30_ONE + e) : div_u64(Q30_ONE << 30, Q30_ONE + e);
		r = (s30 + (64'd1 << 14)) >> 15;
		return r[PROB_W-1:0];
	endfunction

	function automatic logic [W_W-1:0] init_weight(input int idx, input int wfb);
		logic [63:0] h;
		logic [63:0] v;
		unique case (idx)
			0: h = 64'd20;
			1: h = 64'd30;
			2: h = 64'd10;
			3: h = 64'd25;
			4: h = 64'd15;
			5: h = 64'd5;
			6: h = 64'd5;
			7: h = 64'd10;
			8: h = 64'd10;
			default: h = 64'd0;
		endcase
		v = ((h << wfb) + 64'd50) / 64'd100;
		return v[W_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/ols_norm.sv =====
`default_nettype none
module ols_norm (
	input  wire logic [15:0]    complexity_score,
	input  wire logic [23:0]    exec_time_ms,
	input  wire logic [31:0]    result_bytes,
	input  wire logic [15:0]    hit_count,
	input  wire logic [15:0]    locality,
	input  wire logic [7:0]     tables,
	input  wire logic [7:0]     joins,
	input  wire logic           aggregates,
	input  wire logic           subqueries,
	output ols_pkg::feat_t      feat [ols_pkg::NORM_FEATS]
);
	import ols_pkg::*;

	// Constant divides by reciprocal multiplication; both are exact over the input range.
	localparam logic [31:0] RECIP_125 = 32'd2199023256;
	localparam logic [23:0] RECIP_5   = 24'd13421773;

	logic [62:0] ms_prod;
	logic [46:0] tab_prod;
	logic [47:0] join_prod;

	always_comb begin
		ms_prod   = 63'({exec_time_ms[17:0], 13'b0}) * 63'(RECIP_125);
		tab_prod  = 47'({tables, 15'b0}) * 47'(RECIP_5);
		join_prod = 48'({joins, 16'b0}) * 48'(RECIP_5);

		feat[0] = FEAT_W'({complexity_score, 1'b0});
		// Beyond 255999 ms the scaled time no longer fits the feature width.
		feat[1] = (exec_time_ms >= 24'd256000) ? FEAT_SAT : ms_prod[61:38];
		feat[2] = (result_bytes[31:28] != 4'd0) ? FEAT_SAT : result_bytes[27:4];
		feat[3] = (hit_count[15:8] != 8'd0) ? FEAT_SAT : {hit_count[7:0], 16'b0};
		feat[4] = FEAT_W'({locality, 1'b0});
		feat[5] = FEAT_W'(tab_prod[46:26]);
		feat[6] = FEAT_W'(join_prod[47:26]);
		feat[7] = FEAT_W'({aggregates, 16'b0});
		feat[8] = FEAT_W'({subqueries, 16'b0});
	end

endmodule
`default_nettype wire

// ===== design/ols_lane.sv =====
`default_nettype none
module ols_lane #(
	parameter int WFB = 24,
	parameter logic [31:0] W_INIT = 32'd0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ols_pkg::lane_ctrl_t               ctrl,
	input  wire ols_pkg::feat_t                    feat,
	input  wire logic [ols_pkg::RE_W-1:0]          re,
	output logic signed [ols_pkg::PROD_W-1:0]      prod_s2
);
	import ols_pkg::*;

	localparam int PW   = RE_W + FEAT_W;
	localparam int SH   = 46 - WFB;
	localparam int DW   = PW - SH;
	localparam int SUMW = (DW + 2 > W_W + 2) ? DW + 2 : W_W + 2;

	logic signed [W_W-1:0]  w_q;
	logic [DW-1:0]          delta_s3;
	logic [PW-1:0]          full;
	logic signed [SUMW-1:0] w_ext;
	logic signed [SUMW-1:0] d_ext;
	logic signed [SUMW-1:0] w_sum;
	logic signed [W_W-1:0]  w_next;

	always_comb begin
		full  = PW'(re) * PW'(feat);
		w_ext = SUMW'(w_q);
		d_ext = $signed(SUMW'(delta_s3));
		w_sum = ctrl.neg ? (w_ext - d_ext) : (w_ext + d_ext);
		// Saturate to the signed 32-bit range when the upper bits disagree.
		if (w_sum[SUMW-1:W_W-1] != {(SUMW-W_W+1){w_sum[SUMW-1]}}) begin
			w_next = w_sum[SUMW-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
		end else begin
			w_next = w_sum[W_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_INIT;
		end else if (ctrl.upd_en) begin
			w_q <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= w_q * $signed({1'b0, feat});
		end
		if (ctrl.delta_en) begin
			delta_s3 <= full[PW-1:SH];
		end
	end

endmodule
`default_nettype wire

// ===== design/ols_sig_rom.sv =====
`default_nettype none
module ols_sig_rom #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  wire logic                          clk,
	input  wire logic [AW-1:0]                 addr,
	output logic [ols_pkg::PROB_W-1:0]         data_q
);
	import ols_pkg::*;

	logic [PROB_W-1:0] rom [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		localparam logic [PROB_W-1:0] V = sig_entry(64'(g), 64'(DEPTH));
		assign rom[g] = V;
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

endmodule
`default_nettype wire

// ===== design/online_logistic_scorer.sv =====
// Online logistic scorer.
// Input channel (in_valid/in_ready) takes one item of nine query features, a kind bit
// and a utility target. Output channel (out_valid/out_ready) returns one item per input:
// the sigmoid probability from the weights as they stood before the item, and for a
// training item the error utility - probability (zero for a score-only item).
// The per-feature products run in parallel lanes, one per weight; a two-level adder
// tree merges them, and a table lookup gives the probability.
// A result passes the multiply, the adder levels, the index step, the table read and the
// error step before the output register takes it; a training item then also takes the
// rate product, the lane deltas and the weight write. One item is in flight at a time.
// The output register lets the next item enter while a result waits; if the receiver
// stalls with a result still held, the next item waits at its result step.
// Reset loads initial weights, base rate and a decay of 1.0 at once; no clearing pass is
// needed. The configuration port writes the learning rate (also reloading the running
// rate) or decay, one register per cycle; the user must write while idle, unenforced.
`default_nettype none
module online_logistic_scorer #(
	parameter int FEATURE_COUNT = 9,
	parameter int SIGMOID_TABLE_DEPTH = 256,
	parameter int WEIGHT_FRACTION_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire ols_pkg::reg_index_t            cfg_index,
	input  wire logic [ols_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           kind,
	input  wire logic [15:0]                    complexity_score,
	input  wire logic [23:0]                    exec_time_ms,
	input  wire logic [31:0]                    result_bytes,
	input  wire logic [15:0]                    hit_count,
	input  wire logic [15:0]                    locality,
	input  wire logic [7:0]                     tables,
	input  wire logic [7:0]                     joins,
	input  wire logic                           aggregates,
	input  wire logic                           subqueries,
	input  wire logic [15:0]                    utility,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ols_pkg::PROB_W-1:0]          probability,
	output logic signed [ols_pkg::ERR_W-1:0]    train_error
);
	import ols_pkg::*;

	localparam int FB   = WEIGHT_FRACTION_BITS + 16;
	localparam int XW   = FB + 4;
	localparam int AW   = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int DPW  = $clog2(SIGMOID_TABLE_DEPTH + 1);
	localparam int KPW  = XW + DPW;
	localparam int PSW  = PROD_W + 2;
	localparam int SCW  = PROD_W + 4;
	localparam logic signed [SCW-1:0] LIM = $signed(SCW'(64'd1 << (FB + 3)));
	localparam logic [DPW-1:0] K_MAX = DPW'(SIGMOID_TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_SUM1, ST_SUM2, ST_IDX, ST_PROB, ST_ERR, ST_RE, ST_DELTA, ST_UPD
	} state_t;

	state_t state_q;

	feat_t norm_feat [NORM_FEATS];
	feat_t feat_s1 [NF_MAX];
	logic kind_s1;
	logic [15:0] util_s1;
	logic signed [PROD_W-1:0] prod [NF_MAX];
	logic signed [PSW-1:0] part_s3 [4];
	logic signed [SCW-1:0] score_s4;
	logic [AW-1:0] addr_s5;
	logic [PROB_W-1:0] rom_q;
	logic [RATE_W-1:0] rate_q;
	logic [DECAY_W-1:0] decay_q;
	logic [MAG_W-1:0] mag_q;
	logic neg_q;
	logic [RE_W-1:0] re_q;
	logic out_valid_q;
	lane_ctrl_t ctrl;

	logic signed [PSW-1:0] part_c [4];
	logic signed [SCW-1:0] score_c;
	logic signed [SCW-1:0] xs;
	logic [KPW-1:0] kp;
	logic [DPW-1:0] kfull;
	logic [AW-1:0] addr_c;
	logic signed [ERR_W:0] err_c;
	logic [MAG_W-1:0] mag_c;
	logic [RATE_W+MAG_W-1:0] re_full;
	logic [RATE_W+DECAY_W-1:0] rate_full;
	logic [RATE_W-1:0] rate_next;
	logic can_load;

	ols_norm u_norm (
		.complexity_score(complexity_score),
		.exec_time_ms(exec_time_ms),
		.result_bytes(result_bytes),
		.hit_count(hit_count),
		.locality(locality),
		.tables(tables),
		.joins(joins),
		.aggregates(aggregates),
		.subqueries(subqueries),
		.feat(norm_feat)
	);

	for (genvar g = 0; g < NF_MAX; g++) begin : g_lane
		if (g < FEATURE_COUNT) begin : g_on
			localparam logic [W_W-1:0] W_INIT = init_weight(g, WEIGHT_FRACTION_BITS);
			ols_lane #(
				.WFB(WEIGHT_FRACTION_BITS),
				.W_INIT(W_INIT)
			) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.feat(feat_s1[g]),
				.re(re_q),
				.prod_s2(prod[g])
			);
		end else begin : g_off
			assign prod[g] = '0;
		end
	end

	ols_sig_rom #(
		.DEPTH(SIGMOID_TABLE_DEPTH),
		.AW(AW)
	) u_rom (
		.clk(clk),
		.addr(addr_s5),
		.data_q(rom_q)
	);

	always_comb begin
		ctrl.mul_en   = state_q == ST_MUL;
		ctrl.delta_en = state_q == ST_DELTA;
		ctrl.upd_en   = state_q == ST_UPD;
		ctrl.neg      = neg_q;

		for (int j = 0; j < 4; j++) begin
			part_c[j] = PSW'(prod[4*j]) + PSW'(prod[4*j+1])
				+ PSW'(prod[4*j+2]) + PSW'(prod[4*j+3]);
		end
		score_c = SCW'(part_s3[0]) + SCW'(part_s3[1]) + SCW'(part_s3[2]) + SCW'(part_s3[3]);

		// Table index: scores are clamped to [-8, 8) before binning.
		xs = score_s4 + LIM;
		kp = KPW'(xs[XW-1:0]) * KPW'(SIGMOID_TABLE_DEPTH);
		kfull = kp[KPW-1:XW];
		if (score_s4 < -LIM) begin
			addr_c = '0;
		end else if (score_s4 >= LIM || kfull > K_MAX) begin
			addr_c = K_MAX[AW-1:0];
		end else begin
			addr_c = kfull[AW-1:0];
		end

		err_c = $signed({2'b0, util_s1}) - $signed({2'b0, rom_q});
		mag_c = err_c[ERR_W] ? MAG_W'(-err_c) : MAG_W'(err_c);

		re_full = (RATE_W+MAG_W)'(rate_q) * (RATE_W+MAG_W)'(mag_q);
		rate_full = (RATE_W+DECAY_W)'(rate_q) * (RATE_W+DECAY_W)'(decay_q);
		rate_next = (rate_full[RATE_W+DECAY_W-1:RATE_W+16] != '0) ? '1
			: rate_full[RATE_W+15:16];

		can_load = !out_valid_q || out_ready;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rate_q      <= RATE_RESET;
			decay_q     <= DECAY_RESET;
		end else begin
			if (state_q == ST_ERR && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_LEARNING_RATE:    rate_q <= {cfg_data[LR_W-1:0], 16'b0};
					REG_DECAY_PER_UPDATE: decay_q <= cfg_data[DECAY_W-1:0];
					default:              rate_q <= rate_q;
				endcase
			end
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM1;
				ST_SUM1:  state_q <= ST_SUM2;
				ST_SUM2:  state_q <= ST_IDX;
				ST_IDX:   state_q <= ST_PROB;
				ST_PROB:  state_q <= ST_ERR;
				ST_ERR: begin
					if (can_load) begin
						state_q <= kind_s1 ? ST_RE : ST_IDLE;
					end
				end
				ST_RE:    state_q <= ST_DELTA;
				ST_DELTA: state_q <= ST_UPD;
				ST_UPD: begin
					rate_q  <= rate_next;
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			for (int i = 0; i < NF_MAX; i++) begin
				feat_s1[i] <= (i < NORM_FEATS) ? norm_feat[i] : '0;
			end
			kind_s1 <= kind;
			util_s1 <= utility;
		end
		if (state_q == ST_SUM1) begin
			part_s3 <= part_c;
		end
		if (state_q == ST_SUM2) begin
			score_s4 <= score_c;
		end
		if (state_q == ST_IDX) begin
			addr_s5 <= addr_c;
		end
		if (state_q == ST_ERR && can_load) begin
			probability <= rom_q;
			train_error <= kind_s1 ? err_c[ERR_W-1:0] : '0;
			mag_q       <= mag_c;
			neg_q       <= err_c[ERR_W];
		end
		if (state_q == ST_RE) begin
			re_q <= re_full[RATE_W+MAG_W-1:17];
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_online_logistic_scorer.sv =====
`default_nettype none
module tb_online_logistic_scorer;
	timeunit 1ns;
	timeprecision 1ps;
	import ols_pkg::*;

	localparam int NFEAT = 9;
	localparam int TAB_DEPTH = 256;
	localparam int WFB = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_PER_PHASE = 190;

	typedef struct {
		bit kind;
		logic [15:0] cs;
		logic [23:0] ms;
		logic [31:0] rb;
		logic [15:0] ac;
		logic [15:0] loc;
		logic [7:0] tb;
		logic [7:0] jn;
		bit ag;
		bit sq;
		logic [15:0] ut;
	} query_t;

	typedef struct {
		logic [15:0] prob;
		logic signed [16:0] err;
	} score_t;

	typedef struct {
		query_t q;
		bit pin;
		logic signed [16:0] err;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	reg_index_t cfg_index = REG_LEARNING_RATE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [15:0] complexity_score = '0;
	logic [23:0] exec_time_ms = '0;
	logic [31:0] result_bytes = '0;
	logic [15:0] hit_count = '0;
	logic [15:0] locality = '0;
	logic [7:0] tables = '0;
	logic [7:0] joins = '0;
	logic aggregates = 1'b0;
	logic subqueries = 1'b0;
	logic [15:0] utility = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PROB_W-1:0] probability;
	logic signed [ERR_W-1:0] train_error;

	online_logistic_scorer dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scoreboard state and the predictor's copy of the block.
	score_t pending_scores[$];
	logic [15:0] sigmoid_lut[TAB_DEPTH];
	int signed weights[NFEAT];
	logic [31:0] live_rate;
	logic [16:0] decay_q;
	int errors = 0;
	int items_sent = 0;
	int trains_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit ready_always = 1'b0;
	int ready_hold = 0;
	dir_row_t dir_rows[18];

	function automatic longint unsigned exp_neg_q30(longint unsigned t);
		longint unsigned u, m, e;
		longint sum;
		u = t >> 4;
		m = 64'd1 << 30;
		sum = 64'sd1 << 30;
		for (int n = 1; n <= 12; n++) begin
			m = ((m * u) >> 30) / n;
			if (n % 2 == 1) sum -= longint'(m);
			else sum += longint'(m);
		end
		if (sum < 0) sum = 0;
		e = longint'(sum);
		if (e > (64'd1 << 30)) e = 64'd1 << 30;
		for (int s = 0; s < 4; s++) e = (e * e) >> 30;
		return e;
	endfunction

	function automatic logic [15:0] sigmoid_at(int k);
		longint unsigned num, t, e, s30, one;
		longint c;
		one = 64'd1 << 30;
		num = (64'(2 * k + 1)) << 34;
		c = longint'(num / (2 * TAB_DEPTH)) - longint'(64'd8 << 30);
		t = c < 0 ? longint'(-c) : longint'(c);
		e = exp_neg_q30(t);
		s30 = c < 0 ? (e << 30) / (one + e) : (one << 30) / (one + e);
		return 16'((s30 + (64'd1 << 14)) >> 15);
	endfunction

	function automatic longint sat24(longint v);
		return v > 64'hFFFFFF ? 64'hFFFFFF : v;
	endfunction

	function automatic void reset_model();
		int h[NFEAT] = '{20, 30, 10, 25, 15, 5, 5, 10, 10};
		for (int i = 0; i < NFEAT; i++)
			weights[i] = int'(((longint'(h[i]) << WFB) + 50) / 100);
		live_rate = 32'd655 << 16;
		decay_q = 17'd65536;
	endfunction

	// Scores one item and, for a training item, applies the weight and rate update.
	function automatic score_t score_and_learn(query_t q);
		longint f[NFEAT];
		longint acc, lim, k, mag, re, d, w;
		longint unsigned r;
		score_t res;
		f[0] = sat24(longint'(q.cs) << 1);
		f[1] = sat24((longint'(q.ms) << 16) / 1000);
		f[2] = sat24(longint'(q.rb) >> 4);
		f[3] = sat24(longint'(q.ac) << 16);
		f[4] = sat24(longint'(q.loc) << 1);
		f[5] = sat24((longint'(q.tb) << 16) / 10);
		f[6] = sat24((longint'(q.jn) << 16) / 5);
		f[7] = longint'(q.ag) << 16;
		f[8] = longint'(q.sq) << 16;
		acc = 0;
		for (int i = 0; i < NFEAT; i++) acc += longint'(weights[i]) * f[i];
		lim = 64'sd1 << (WFB + 16 + 3);
		if (acc < -lim) k = 0;
		else if (acc >= lim) k = TAB_DEPTH - 1;
		else k = ((acc + lim) * TAB_DEPTH) >>> (WFB + 16 + 4);
		if (k > TAB_DEPTH - 1) k = TAB_DEPTH - 1;
		res.prob = sigmoid_lut[k];
		res.err = '0;
		if (q.kind) begin
			res.err = 17'(int'(q.ut) - int'(res.prob));
			mag = res.err < 0 ? -longint'(res.err) : longint'(res.err);
			re = (longint'({32'b0, live_rate}) * mag) >> 17;
			for (int i = 0; i < NFEAT; i++) begin
				d = (re * f[i]) >> (46 - WFB);
				w = longint'(weights[i]) + (res.err < 0 ? -d : d);
				if (w > 64'sh7FFFFFFF) w = 64'sh7FFFFFFF;
				if (w < -64'sh80000000) w = -64'sh80000000;
				weights[i] = int'(w);
			end
			r = (longint'({32'b0, live_rate}) * longint'(decay_q)) >> 16;
			live_rate = r > 64'hFFFFFFFF ? 32'hFFFFFFFF : 32'(r);
		end
		return res;
	endfunction

	function automatic query_t mk(bit kd, logic [15:0] cs, logic [23:0] ms, logic [31:0] rb,
			logic [15:0] ac, logic [15:0] loc, logic [7:0] tb, logic [7:0] jn, bit ag, bit sq,
			logic [15:0] ut);
		query_t q;
		q.kind = kd; q.cs = cs; q.ms = ms; q.rb = rb; q.ac = ac; q.loc = loc;
		q.tb = tb; q.jn = jn; q.ag = ag; q.sq = sq; q.ut = ut;
		return q;
	endfunction

	// Field values spread over every magnitude, with both ends hit often.
	function automatic logic [31:0] rand_bits(int w);
		int pick;
		logic [31:0] v;
		pick = $urandom_range(0, 15);
		v = $urandom;
		if (pick == 0) return '0;
		if (pick == 1) return 32'hFFFFFFFF >> (32 - w);
		return v & (32'hFFFFFFFF >> (32 - $urandom_range(1, w)));
	endfunction

	function automatic query_t rand_query();
		return mk($urandom_range(0, 1), 16'(rand_bits(16)), 24'(rand_bits(24)),
			rand_bits(32), 16'(rand_bits(16)), 16'(rand_bits(16)), 8'(rand_bits(8)),
			8'(rand_bits(8)), $urandom_range(0, 1), $urandom_range(0, 1),
			16'(rand_bits(16)));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_query(query_t q, bit pin, logic signed [16:0] pin_err);
		int gap;
		score_t exp_score;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= q.kind;
		complexity_score <= q.cs;
		exec_time_ms <= q.ms;
		result_bytes <= q.rb;
		hit_count <= q.ac;
		locality <= q.loc;
		tables <= q.tb;
		joins <= q.jn;
		aggregates <= q.ag;
		subqueries <= q.sq;
		utility <= q.ut;
		do @(posedge clk); while (!in_ready);
		exp_score = score_and_learn(q);
		if (pin) exp_score.err = pin_err;
		pending_scores.push_back(exp_score);
		items_sent++;
		if (q.kind) trains_sent++;
	endtask

	// A training item keeps the block busy past its result, for its weight update.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_LEARNING_RATE) begin
			live_rate = {16'(val), 16'b0};
		end else begin
			decay_q = val;
		end
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if (!ready_always && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		score_t exp_score;
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_scores.size() == 0) begin
				$display("%t: result with none expected: prob %0d err %0d", $time,
					probability, train_error);
				errors++;
			end else begin
				exp_score = pending_scores.pop_front();
				if (probability !== exp_score.prob) begin
					$display("%t: probability expected %0d actual %0d", $time,
						exp_score.prob, probability);
					errors++;
				end
				if (train_error !== exp_score.err) begin
					$display("%t: train_error expected %0d actual %0d", $time,
						exp_score.err, train_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [15:0] lr_set[8];
		logic [16:0] decay_set[8];
		lr_set = '{16'd65535, 16'd0, 16'd1000, 16'd65535, 16'd0, 16'd655,
			16'd0, 16'd20000};
		decay_set = '{17'd65536, 17'd65536, 17'd0, 17'd131071, 17'd65535,
			17'd60000, 17'd0, 17'd65536};
		for (int k = 0; k < TAB_DEPTH; k++) sigmoid_lut[k] = sigmoid_at(k);
		reset_model();
		lr_set[4] = 16'($urandom);
		lr_set[6] = 16'($urandom);
		decay_set[6] = 17'($urandom);
		// Score-only rows must report a zero error.
		dir_rows[0] = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[1] = '{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0};
		dir_rows[2] = '{mk(0, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF, 1, 1, 16'hFFFF), 1, 0};
		dir_rows[3] = '{mk(0, 16'd32768, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[4] = '{mk(0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[5] = '{mk(0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[6] = '{mk(0, 0, 0, 0, 16'd1, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[7] = '{mk(0, 0, 0, 0, 0, 16'd32768, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[8] = '{mk(0, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0), 1, 0};
		dir_rows[9] = '{mk(0, 0, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0), 1, 0};
		dir_rows[10] = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0), 1, 0};
		dir_rows[11] = '{mk(1, 16'd16384, 24'd500, 32'd1048576, 16'd2, 16'd8192, 8'd3, 8'd1,
			1, 0, 16'd32768), 0, 0};
		dir_rows[12] = '{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, 0};
		// Driving every weight far negative so the next row clamps at the low end.
		dir_rows[13] = '{mk(1, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF, 1, 1, 16'd0), 0, 0};
		dir_rows[14] = '{mk(0, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF, 1, 1, 16'd0), 1, 0};
		dir_rows[15] = '{mk(1, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF, 1, 1, 16'hFFFF), 0, 0};
		dir_rows[16] = '{mk(0, 0, 0, 0, 16'd255, 0, 0, 0, 0, 0, 0), 1, 0};
		dir_rows[17] = '{mk(1, 16'd100, 24'd20, 32'd4096, 16'd0, 16'd300, 8'd1, 8'd0, 0, 1,
			16'd16384), 0, 0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].pin, dir_rows[i].err);
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			ready_always = (ph % 3 == 2);
			write_reg(REG_DECAY_PER_UPDATE, decay_set[ph]);
			write_reg(REG_LEARNING_RATE, 17'(lr_set[ph]));
			for (int n = 0; n < RAND_PER_PHASE; n++) send_query(rand_query(), 0, 0);
		end
		wait_idle();
		$display("Sent %0d items (%0d training) over 9 rate and decay settings;", items_sent,
			trains_sent);
		$display("checked %0d results with random gaps and output stalls.", results_seen);
		if (errors == 0 && pending_scores.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
